// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on aclk with reset masking.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TTOI_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("ttoi assertion failed");

// Condition must never be true outside reset.
`define TTOI_NEVER(label, cond) \
    `TTOI_ASSERT(label, !(cond))

`endif

// ===== sv/ttoi_pkg.sv =====
// ---------------------------------------------------------------------------
// ttoi_pkg
// Types and constants shared by the text to integer parser.
// ---------------------------------------------------------------------------
package ttoi_pkg;

    localparam int MaxAlphabet = 16;
    localparam int ChrW        = 8;
    localparam int LenW        = 5;
    localparam int DigitW      = (MaxAlphabet > 1) ? $clog2(MaxAlphabet) : 1;
    localparam int ValueW      = 32;
    localparam int CfgDataW    = 64;
    localparam int CfgAddrW    = 2;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int QueueCntW   = $clog2(QueueDepth + 1);

    localparam logic [CfgAddrW-1:0] CfgAlphaLow  = 2'd0;
    localparam logic [CfgAddrW-1:0] CfgAlphaHigh = 2'd1;
    localparam logic [CfgAddrW-1:0] CfgAlphaLen  = 2'd2;

    localparam logic [ChrW-1:0] ChrPlus  = 8'h2B;
    localparam logic [ChrW-1:0] ChrMinus = 8'h2D;
    localparam logic [ChrW-1:0] ChrSpace = 8'h20;
    localparam logic [ChrW-1:0] ChrTab   = 8'h09;
    localparam logic [ChrW-1:0] ChrNl    = 8'h0A;
    localparam logic [ChrW-1:0] ChrVt    = 8'h0B;
    localparam logic [ChrW-1:0] ChrFf    = 8'h0C;
    localparam logic [ChrW-1:0] ChrCr    = 8'h0D;
    localparam logic [ChrW-1:0] ChrNul   = 8'h00;

    typedef struct packed {
        logic [MaxAlphabet-1:0][ChrW-1:0] alpha;
        logic [LenW-1:0]                  used_len;
        logic                             bad;
    } ttoi_cfg_t;

    typedef struct packed {
        logic              is_space;
        logic              is_sign;
        logic              is_minus;
        logic              is_digit;
        logic [DigitW-1:0] digit;
        logic              last;
    } ttoi_item_t;

    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } ttoi_phase_t;

endpackage

// ===== sv/ttoi_cfg.sv =====
// ---------------------------------------------------------------------------
// ttoi_cfg
// Alphabet registers, used length saturation and alphabet validity check.
// ---------------------------------------------------------------------------
module ttoi_cfg
    import ttoi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wr_data,
    output ttoi_cfg_t           cfg
);

    logic [CfgDataW-1:0]              alpha_lo_reg;
    logic [CfgDataW-1:0]              alpha_hi_reg;
    logic [LenW-1:0]                  len_reg;
    logic                             bad_reg;
    logic                             bad_next;
    logic [2*CfgDataW-1:0]            alpha_all;
    logic [MaxAlphabet-1:0][ChrW-1:0] alpha;
    logic [LenW-1:0]                  used_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_lo_reg <= '0;
            alpha_hi_reg <= '0;
            len_reg      <= '0;
            bad_reg      <= 1'b1;
        end else begin
            bad_reg <= bad_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CfgAlphaLow:  alpha_lo_reg <= cfg_wr_data;
                    CfgAlphaHigh: alpha_hi_reg <= cfg_wr_data;
                    CfgAlphaLen:  len_reg      <= cfg_wr_data[LenW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign alpha_all = {alpha_hi_reg, alpha_lo_reg};
    assign alpha     = alpha_all[MaxAlphabet*ChrW-1:0];
    assign used_len  = (len_reg > LenW'(MaxAlphabet)) ? LenW'(MaxAlphabet) : len_reg;

    always_comb begin
        bad_next = (used_len < LenW'(2));
        for (int i = 0; i < MaxAlphabet; i++) begin
            if (LenW'(i) < used_len) begin
                if (alpha[i] == ChrNul || alpha[i] == ChrPlus || alpha[i] == ChrMinus) begin
                    bad_next = 1'b1;
                end
                for (int j = i + 1; j < MaxAlphabet; j++) begin
                    if (LenW'(j) < used_len && alpha[j] == alpha[i]) begin
                        bad_next = 1'b1;
                    end
                end
            end
        end
    end

    assign cfg.alpha    = alpha;
    assign cfg.used_len = used_len;
    assign cfg.bad      = bad_reg;

endmodule

// ===== sv/ttoi_front.sv =====
// ---------------------------------------------------------------------------
// ttoi_front
// Accepts characters and classifies each as whitespace, sign or digit.
// ---------------------------------------------------------------------------
module ttoi_front
    import ttoi_pkg::*;
(
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [ChrW-1:0] s_tdata,   // [7:0] character
    input  logic            s_tlast,
    input  ttoi_cfg_t       cfg,
    input  logic            queue_full,
    output logic            push,
    output ttoi_item_t      item
);

    logic [ChrW-1:0]   ch;
    logic              hit;
    logic [DigitW-1:0] idx;

    assign ch       = s_tdata;
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = MaxAlphabet - 1; i >= 0; i--) begin
            if (LenW'(i) < cfg.used_len && ch == cfg.alpha[i]) begin
                hit = 1'b1;
                idx = DigitW'(i);
            end
        end
    end

    assign item.is_space = (ch == ChrSpace) || (ch == ChrTab) || (ch == ChrNl)
                        || (ch == ChrVt) || (ch == ChrFf) || (ch == ChrCr);
    assign item.is_sign  = (ch == ChrPlus) || (ch == ChrMinus);
    assign item.is_minus = (ch == ChrMinus);
    assign item.is_digit = hit;
    assign item.digit    = idx;
    assign item.last     = s_tlast;

endmodule

// ===== sv/ttoi_queue.sv =====
// ---------------------------------------------------------------------------
// ttoi_queue
// Short FIFO of classified characters between the front and back parts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttoi_queue
    import ttoi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ttoi_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output ttoi_item_t head
);

    ttoi_item_t           entries [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueueCntW-1:0] count_reg;
    logic [QueueCntW-1:0] count_next;

    assign full      = (count_reg == QueueCntW'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QueueCntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QueueCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QueuePtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QueuePtrW'(1);
            end
        end
    end

    `TTOI_NEVER(a_queue_overfill, count_reg > QueueCntW'(QueueDepth))
    `TTOI_NEVER(a_pop_empty, pop && !not_empty)
    `TTOI_ASSERT(a_push_full, full |-> !push)

endmodule

// ===== sv/ttoi_back.sv =====
// ---------------------------------------------------------------------------
// ttoi_back
// Parser state machine, Horner accumulation and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttoi_back
    import ttoi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ttoi_cfg_t         cfg,
    input  logic              item_valid,
    input  ttoi_item_t        item,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ValueW-1:0] m_tdata,   // [31:0] value
    output logic              m_tuser    // [0] alphabet_invalid
);

    ttoi_phase_t       phase_reg;
    ttoi_phase_t       phase_next;
    logic              neg_reg;
    logic              neg_next;
    logic [ValueW-1:0] acc_reg;
    logic [ValueW-1:0] acc_next;
    logic [ValueW-1:0] acc_mul;
    logic              m_valid_reg;
    logic [ValueW-1:0] m_value_reg;
    logic              m_invalid_reg;

    assign pop     = item_valid && (!item.last || !m_valid_reg || m_tready);
    assign acc_mul = acc_reg * {{(ValueW-LenW){1'b0}}, cfg.used_len};

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (phase_reg != PH_DONE) begin
            if (phase_reg == PH_SPACE && item.is_space) begin
                phase_next = PH_SPACE;
            end else if ((phase_reg == PH_SPACE || phase_reg == PH_SIGN) && item.is_sign) begin
                neg_next   = neg_reg ^ item.is_minus;
                phase_next = PH_SIGN;
            end else if (item.is_digit) begin
                acc_next   = acc_mul + {{(ValueW-DigitW){1'b0}}, item.digit};
                phase_next = PH_DIGIT;
            end else begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SPACE;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (item.last) begin
                    phase_reg <= PH_SPACE;
                    neg_reg   <= 1'b0;
                    acc_reg   <= '0;
                end else begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    acc_reg   <= acc_next;
                end
            end
            if (pop && item.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && item.last) begin
            m_invalid_reg <= cfg.bad;
            if (cfg.bad) begin
                m_value_reg <= '0;
            end else if (neg_next) begin
                m_value_reg <= '0 - acc_next;
            end else begin
                m_value_reg <= acc_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_invalid_reg;

    `TTOI_ASSERT(a_result_from_last, $rose(m_valid_reg) |-> $past(pop && item.last))
    `TTOI_ASSERT(a_invalid_zero, (m_valid_reg && m_invalid_reg) |-> (m_value_reg == '0))

endmodule

// ===== sv/text_to_integer_any_base.sv =====
// ---------------------------------------------------------------------------
// text_to_integer_any_base
// Parses a signed integer from a byte stream in a configurable digit alphabet.
// ---------------------------------------------------------------------------
// The block takes one character per clock while the queue is not full, and
// returns one result per string, loaded when the back stage pops the byte
// marked by s_tlast. A front stage classifies each byte against the alphabet
// with parallel compares, and a four-entry queue holds the classified bytes.
// A back stage updates the sign and the 32-bit Horner accumulator at one byte
// per cycle, using one 32 by 5 bit multiply per byte. The result register lets
// the next string stream in while a result waits; only its last byte is held.
// ---------------------------------------------------------------------------
module text_to_integer_any_base
    import ttoi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ChrW-1:0]     s_tdata,   // [7:0] character
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ValueW-1:0]   m_tdata,   // [31:0] value
    output logic                m_tuser    // [0] alphabet_invalid
);

    ttoi_cfg_t  cfg;
    ttoi_item_t front_item;
    ttoi_item_t head_item;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_not_empty;

    ttoi_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    ttoi_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    ttoi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head_item)
    );

    ttoi_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
